>>> rtl/edge_shrinking_window_average_unit_macros.svh
// Assertion macros shared by the checker of the window average unit.
`ifndef EDGE_SHRINKING_WINDOW_AVERAGE_UNIT_MACROS_SVH
`define EDGE_SHRINKING_WINDOW_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ESW_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ESW_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is applied.
`define ESW_ASSERT_RESET(name, clk, rst, cons, msg) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

>>> rtl/esw_pkg.sv
// Shared types and constants of the window average unit.
package esw_pkg;

  localparam int VALUE_BITS     = 16;
  localparam int INDEX_BITS     = 20;
  localparam int HALF_BITS      = 5;
  localparam int SUM_BITS       = 22;
  localparam int HIST_AW        = 7;
  localparam int HIST_DEPTH     = 1 << HIST_AW;
  localparam int QUEUE_AW       = 2;
  localparam int QUEUE_DEPTH    = 1 << QUEUE_AW;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 20;
  localparam int OUT_DATA_BITS  = 40;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WINDOW  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 1'b1;

  typedef enum logic {
    JOB_RAW,
    JOB_SMOOTH
  } job_kind_t;

  // For a smoothing job, index is the last column to produce.
  typedef struct packed {
    job_kind_t               kind;
    logic [VALUE_BITS-1:0]   value;
    logic [INDEX_BITS-1:0]   index;
    logic                    last;
    logic                    big;
    logic [INDEX_BITS-1:0]   count;
    logic [HALF_BITS-1:0]    half;
    logic [HIST_AW-1:0]      base;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [HIST_AW-1:0]    addr;
    logic [VALUE_BITS-1:0] data;
  } hist_wr_t;

endpackage

>>> rtl/esw_front.sv
// Front end: configuration registers, stream tracking and job issue.
module esw_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [esw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [esw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [esw_pkg::VALUE_BITS-1:0]       s_axis_tdata,
  input  logic                                 queue_full,
  output logic                                 push,
  output esw_pkg::job_t                        push_job,
  output esw_pkg::hist_wr_t                    hist_wr
);

  logic [esw_pkg::HALF_BITS-1:0]  half_window;
  logic [esw_pkg::INDEX_BITS-1:0] column_count;
  logic [esw_pkg::INDEX_BITS-1:0] arrival;
  logic [esw_pkg::INDEX_BITS-1:0] run_count;
  logic [esw_pkg::HALF_BITS-1:0]  run_half;
  logic                           run_big;
  logic                           run_raw;
  logic [esw_pkg::HIST_AW-1:0]    base;
  logic [esw_pkg::HIST_AW-1:0]    wp;

  logic                           first;
  logic [esw_pkg::INDEX_BITS-1:0] cfg_count;
  logic                           cfg_big;
  logic [esw_pkg::INDEX_BITS-1:0] cur_count;
  logic [esw_pkg::HALF_BITS-1:0]  cur_half;
  logic                           cur_big;
  logic                           cur_raw;
  logic [esw_pkg::HIST_AW-1:0]    cur_base;
  logic                           is_last;
  logic                           smooth_due;
  logic                           accept;

  always_comb begin
    first      = (arrival == '0);
    cfg_count  = (column_count == '0) ? esw_pkg::INDEX_BITS'(1) : column_count;
    cfg_big    = {15'd0, half_window} > {2'b00, cfg_count[esw_pkg::INDEX_BITS-1:2]};
    cur_count  = first ? cfg_count : run_count;
    cur_half   = first ? half_window : run_half;
    cur_big    = first ? cfg_big : run_big;
    cur_raw    = first ? ((half_window == '0) || cfg_big) : run_raw;
    cur_base   = first ? wp : base;
    is_last    = ({1'b0, arrival} + 21'd1) >= {1'b0, cur_count};
    smooth_due = arrival >= {15'd0, cur_half};
    accept     = s_axis_tvalid && s_axis_tready;
  end

  assign s_axis_tready = !queue_full;
  assign push          = accept && (cur_raw || is_last || smooth_due);

  always_comb begin
    push_job.kind  = cur_raw ? esw_pkg::JOB_RAW : esw_pkg::JOB_SMOOTH;
    push_job.value = s_axis_tdata;
    push_job.index = (cur_raw || is_last) ? arrival : (arrival - {15'd0, cur_half});
    push_job.last  = is_last;
    push_job.big   = cur_big;
    push_job.count = cur_count;
    push_job.half  = cur_half;
    push_job.base  = cur_base;
    hist_wr.en     = accept;
    hist_wr.addr   = wp;
    hist_wr.data   = s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window  <= '0;
      column_count <= esw_pkg::INDEX_BITS'(1);
      arrival      <= '0;
      run_count    <= esw_pkg::INDEX_BITS'(1);
      run_half     <= '0;
      run_big      <= 1'b0;
      run_raw      <= 1'b1;
      wp           <= '0;
      base         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          esw_pkg::CFG_HALF_WINDOW:  half_window  <= cfg_data[esw_pkg::HALF_BITS-1:0];
          esw_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        wp <= wp + esw_pkg::HIST_AW'(1);
        if (first) begin
          run_count <= cfg_count;
          run_half  <= half_window;
          run_big   <= cfg_big;
          run_raw   <= (half_window == '0) || cfg_big;
          base      <= wp;
        end
        arrival <= is_last ? '0 : (arrival + esw_pkg::INDEX_BITS'(1));
      end
    end
  end

endmodule

>>> rtl/esw_queue.sv
// Short job queue between the front end and the back end.
module esw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  esw_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output esw_pkg::job_t head
);

  esw_pkg::job_t                entries [esw_pkg::QUEUE_DEPTH];
  logic [esw_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [esw_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [esw_pkg::QUEUE_AW:0]   fill;

  assign full  = (fill == (esw_pkg::QUEUE_AW + 1)'(esw_pkg::QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + esw_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + esw_pkg::QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (esw_pkg::QUEUE_AW + 1)'(1);
        2'b01:   fill <= fill - (esw_pkg::QUEUE_AW + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/esw_back.sv
// Back end: sample history, running window sum, divider and result register.
module esw_back (
  input  logic                                clk,
  input  logic                                rst,
  input  esw_pkg::hist_wr_t                   hist_wr,
  input  logic                                q_valid,
  input  esw_pkg::job_t                       q_head,
  output logic                                pop,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [esw_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_UP,
    MODE_SAME,
    MODE_DOWN
  } mode_t;

  logic [esw_pkg::VALUE_BITS-1:0] hist [esw_pkg::HIST_DEPTH];
  logic [esw_pkg::VALUE_BITS-1:0] rd0;
  logic [esw_pkg::VALUE_BITS-1:0] rd1;

  state_t                         state;
  mode_t                          mode;
  esw_pkg::job_t                  job;
  logic [esw_pkg::INDEX_BITS-1:0] col;
  logic [esw_pkg::HALF_BITS-1:0]  k;
  logic [esw_pkg::HALF_BITS-1:0]  knew;
  logic [esw_pkg::SUM_BITS-1:0]   sum;
  logic [6:0]                     rem;
  logic [esw_pkg::VALUE_BITS-1:0] quo;
  logic [2:0]                     div_cnt;
  logic [esw_pkg::VALUE_BITS-1:0] out_value;
  logic [esw_pkg::INDEX_BITS-1:0] out_index;

  logic                           init;
  logic [esw_pkg::INDEX_BITS-1:0] c_next;
  logic [esw_pkg::INDEX_BITS-1:0] c_right;
  logic [esw_pkg::INDEX_BITS-1:0] c_edge;
  logic [esw_pkg::HALF_BITS-1:0]  k_calc;
  logic [esw_pkg::HIST_AW-1:0]    a_hi;
  logic [esw_pkg::HIST_AW-1:0]    a_lo;
  logic [esw_pkg::HIST_AW-1:0]    addr0;
  logic [esw_pkg::HIST_AW-1:0]    addr1;
  logic [esw_pkg::SUM_BITS-1:0]   ext0;
  logic [esw_pkg::SUM_BITS-1:0]   ext1;
  logic [esw_pkg::SUM_BITS-1:0]   sum_next;
  logic [5:0]                     divisor;
  logic [22:0]                    step1;
  logic [22:0]                    step2;
  logic                           out_free;
  logic                           is_raw;

  // One restoring division step: returns the new remainder and shifted quotient.
  function automatic logic [22:0] div_step(logic [6:0] r, logic [15:0] q, logic [5:0] d);
    logic [6:0] t;
    logic       b;
    t = {r[5:0], q[15]};
    b = (t >= {1'b0, d});
    if (b) begin
      t = t - {1'b0, d};
    end
    return {t, q[14:0], b};
  endfunction

  always_ff @(posedge clk) begin
    if (hist_wr.en) begin
      hist[hist_wr.addr] <= hist_wr.data;
    end
    rd0 <= hist[addr0];
    rd1 <= hist[addr1];
  end

  always_comb begin
    is_raw  = (job.kind == esw_pkg::JOB_RAW);
    init    = (job.index == '0);
    c_next  = init ? '0 : (col + esw_pkg::INDEX_BITS'(1));
    c_right = job.count - esw_pkg::INDEX_BITS'(1) - c_next;
    c_edge  = (c_next < c_right) ? c_next : c_right;
    k_calc  = (c_edge < {15'd0, job.half}) ? c_edge[esw_pkg::HALF_BITS-1:0] : job.half;

    a_hi = job.base + col[esw_pkg::HIST_AW-1:0] + {2'b00, k};
    a_lo = job.base + col[esw_pkg::HIST_AW-1:0] - {2'b00, k} - esw_pkg::HIST_AW'(1);
    unique case (mode)
      MODE_INIT: begin
        addr0 = a_hi;
        addr1 = a_hi;
      end
      MODE_UP: begin
        addr0 = a_hi;
        addr1 = a_hi + esw_pkg::HIST_AW'(1);
      end
      MODE_SAME: begin
        addr0 = a_hi;
        addr1 = a_lo;
      end
      MODE_DOWN: begin
        addr0 = a_lo;
        addr1 = a_lo + esw_pkg::HIST_AW'(1);
      end
      default: begin
        addr0 = a_hi;
        addr1 = a_lo;
      end
    endcase

    ext0 = {6'd0, rd0};
    ext1 = {6'd0, rd1};
    unique case (mode)
      MODE_INIT: sum_next = ext0;
      MODE_UP:   sum_next = sum + ext0 + ext1;
      MODE_SAME: sum_next = sum + ext0 - ext1;
      MODE_DOWN: sum_next = sum - ext0 - ext1;
      default:   sum_next = sum;
    endcase

    divisor  = {k, 1'b1};
    step1    = div_step(rem, quo, divisor);
    step2    = div_step(step1[22:16], step1[15:0], divisor);
    out_free = !m_axis_tvalid || m_axis_tready;
  end

  assign pop          = (state == ST_IDLE) && q_valid;
  assign m_axis_tdata = {4'd0, out_index, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_INIT;
      k             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            job   <= q_head;
            state <= (q_head.kind == esw_pkg::JOB_RAW) ? ST_OUT : ST_CALC;
          end
        end
        ST_CALC: begin
          col  <= c_next;
          knew <= k_calc;
          if (init) begin
            mode <= MODE_INIT;
            k    <= '0;
          end else if ({1'b0, k_calc} == ({1'b0, k} + 6'd1)) begin
            mode <= MODE_UP;
          end else if (k_calc == k) begin
            mode <= MODE_SAME;
          end else begin
            mode <= MODE_DOWN;
          end
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum     <= sum_next;
          rem     <= {1'b0, sum_next[esw_pkg::SUM_BITS-1:16]};
          quo     <= sum_next[15:0];
          k       <= knew;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= step2[22:16];
          quo     <= step2[15:0];
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_value     <= is_raw ? job.value : quo;
            out_index     <= is_raw ? job.index : col;
            m_axis_tlast  <= job.last && (is_raw || (col == job.index));
            m_axis_tuser  <= is_raw && job.big;
            state         <= (!is_raw && (col != job.index)) ? ST_CALC : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/edge_shrinking_window_average_unit.sv
// Top level of the centered moving average unit with shrinking edges.
// Columns stream in on s_axis, one 16-bit value per transfer, and each produces the windowed
// mean of a column further back once enough neighbors have arrived; the last column of a run
// flushes the pending results. If half_window is zero or too big for column_count, columns
// pass through raw. half_window and column_count are sampled at the first column of a run.
// Input transfers are taken one per cycle while the four-entry job queue has room. A raw job
// goes from being picked straight to the result register. A smoothed result passes through
// picking the job, computing the shrinking window size, the two history reads, updating the
// running window sum, the divider, which produces two quotient bits per cycle, and loading
// the result register; further end-of-run flush columns restart at the window size step.
module edge_shrinking_window_average_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [esw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [esw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [esw_pkg::VALUE_BITS-1:0]      s_axis_tdata,   // [15:0] gap_value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [esw_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,   // [15:0] smoothed_value,
                                                              // [35:16] column_index
  output logic                                m_axis_tlast,   // final_column
  output logic                                m_axis_tuser    // [0] window_too_big
);

  logic              queue_full;
  logic              push;
  esw_pkg::job_t     push_job;
  esw_pkg::hist_wr_t hist_wr;
  logic              pop;
  logic              q_valid;
  esw_pkg::job_t     q_head;

  esw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full    (queue_full),
    .push          (push),
    .push_job      (push_job),
    .hist_wr       (hist_wr)
  );

  esw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  esw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .hist_wr       (hist_wr),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> rtl/esw_checker.sv
// Port-level checker of the window average unit and its bind.
`include "edge_shrinking_window_average_unit_macros.svh"

module esw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [esw_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  input logic                                m_axis_tlast,
  input logic                                m_axis_tuser
);

  logic [esw_pkg::OUT_DATA_BITS+1:0] out_bus;
  logic                              out_stall;

  assign out_bus   = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `ESW_ASSERT_RESET(a_reset_clears_out, clk, rst, !m_axis_tvalid, "output valid after reset")
  `ESW_ASSERT_NOW(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[39:36] == 4'd0, "pad set")
  `ESW_ASSERT_NEXT(a_hold_valid, clk, rst, out_stall, m_axis_tvalid, "valid dropped")
  `ESW_ASSERT_NEXT(a_hold_data, clk, rst, out_stall, $stable(out_bus), "stalled result changed")

endmodule

bind edge_shrinking_window_average_unit esw_checker u_checker (.*);
